// File: src/pmba_pkg.sv
// Shared types and constants for the phased multichannel boxcar averager.
`default_nettype none

package pmba_pkg;

   localparam int SAMPLE_WIDTH = 12;
   localparam int PHASE_WIDTH = 2;

   localparam int DEF_RING_DEPTH = 32;
   localparam int DEF_KNOB_WINDOW_LOG2 = 5;
   localparam int DEF_CV_WINDOW_LOG2 = 3;

   typedef enum logic [PHASE_WIDTH-1:0] {
      PHASE_ZERO   = 2'd0,
      PHASE_PAIR_A = 2'd1,
      PHASE_PAIR_B = 2'd2,
      PHASE_WRAP   = 2'd3
   } phase_type;

   typedef struct packed {
      phase_type                phase;
      logic [SAMPLE_WIDTH-1:0]  knob1_sample;
      logic [SAMPLE_WIDTH-1:0]  knob2_sample;
      logic [SAMPLE_WIDTH-1:0]  knob3_sample;
      logic [SAMPLE_WIDTH-1:0]  cv_sample;
   } req_item_type;

   typedef struct packed {
      phase_type                next_phase;
      logic [SAMPLE_WIDTH-1:0]  knob1_average;
      logic [SAMPLE_WIDTH-1:0]  knob2_average;
      logic [SAMPLE_WIDTH-1:0]  knob3_average;
      logic [SAMPLE_WIDTH-1:0]  cv_average;
   } rsp_item_type;

endpackage

`default_nettype wire

// File: src/pmba_cell.sv
// One slot of a sample shift chain: loads from its neighbor on each update.
`default_nettype none

module pmba_cell #(
   parameter int WIDTH = 24
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             shift_en,
   input  wire logic [WIDTH-1:0] d,
   output logic      [WIDTH-1:0] q
);

   logic [WIDTH-1:0] q_ff;
   logic [WIDTH-1:0] q_in;

   assign q_in = shift_en ? d : q_ff;
   assign q = q_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         q_ff <= '0;
      end else begin
         q_ff <= q_in;
      end
   end

endmodule

`default_nettype wire

// File: src/pmba_accum.sv
// Running sum of one channel: add the new sample, drop the one leaving the window.
`default_nettype none

module pmba_accum #(
   parameter int WINDOW_LOG2 = 5
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              update,
   input  wire logic [pmba_pkg::SAMPLE_WIDTH-1:0] sample,
   input  wire logic [pmba_pkg::SAMPLE_WIDTH-1:0] old_sample,
   output logic      [pmba_pkg::SAMPLE_WIDTH-1:0] average
);

   import pmba_pkg::*;

   localparam int SUM_WIDTH = SAMPLE_WIDTH + WINDOW_LOG2;

   logic [SUM_WIDTH-1:0] sum_ff;
   logic [SUM_WIDTH-1:0] sum_in;

   always_comb begin
      sum_in = sum_ff;
      if (update) begin
         sum_in = sum_ff + SUM_WIDTH'(sample) - SUM_WIDTH'(old_sample);
      end
   end

   // Average of the sum as it stands after this item.
   assign average = sum_in[WINDOW_LOG2 +: SAMPLE_WIDTH];

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
      end else begin
         sum_ff <= sum_in;
      end
   end

endmodule

`default_nettype wire

// File: src/phased_multichannel_boxcar_average_unit.sv
// Top level of the phased multichannel boxcar averager.
//
//   Channel   Ports                          Direction  Moves
//   request   req_valid req_stall req_item   in         phase and four samples
//   response  rsp_valid rsp_stall rsp_item   out        next phase and four averages
//
// One item is accepted every cycle while req_stall is low; its result is registered, in the skid entry on a stall.
// A pair A or B item costs one add and subtract per sum of its pair and one step of its chain; others update none.
// Reset clears every chain cell and every sum in the same cycle, no clearing pass.
// A two-entry output buffer absorbs a stall; req_stall is high only while both are full.
`default_nettype none

module phased_multichannel_boxcar_average_unit #(
   parameter int RING_DEPTH       = pmba_pkg::DEF_RING_DEPTH,
   parameter int KNOB_WINDOW_LOG2 = pmba_pkg::DEF_KNOB_WINDOW_LOG2,
   parameter int CV_WINDOW_LOG2   = pmba_pkg::DEF_CV_WINDOW_LOG2
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire pmba_pkg::req_item_type req_item,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output pmba_pkg::rsp_item_type      rsp_item
);

   import pmba_pkg::*;

   localparam int PAIR_WIDTH = 2 * SAMPLE_WIDTH;
   // Places back in the chain of the sample leaving each window.
   localparam int KNOB_LAG = ((2 ** KNOB_WINDOW_LOG2 - 1) % RING_DEPTH) + 1;
   localparam int CV_LAG   = ((2 ** CV_WINDOW_LOG2 - 1) % RING_DEPTH) + 1;

   logic in_acc;
   logic out_take;
   logic upd_a;
   logic upd_b;

   logic [PAIR_WIDTH-1:0] tap_a [RING_DEPTH];
   logic [PAIR_WIDTH-1:0] tap_b [RING_DEPTH];
   logic [PAIR_WIDTH-1:0] head_a;
   logic [PAIR_WIDTH-1:0] head_b;

   logic [SAMPLE_WIDTH-1:0] old_k1;
   logic [SAMPLE_WIDTH-1:0] old_k2;
   logic [SAMPLE_WIDTH-1:0] old_k3;
   logic [SAMPLE_WIDTH-1:0] old_cv;

   rsp_item_type new_item;
   phase_type    next_phase;

   logic         rsp_valid_ff;
   logic         rsp_valid_in;
   rsp_item_type rsp_item_ff;
   rsp_item_type rsp_item_in;
   logic         skid_valid_ff;
   logic         skid_valid_in;
   rsp_item_type skid_item_ff;
   rsp_item_type skid_item_in;

   assign req_stall = skid_valid_ff;
   assign in_acc    = req_valid && !skid_valid_ff;
   assign out_take  = rsp_valid_ff && !rsp_stall;
   assign upd_a     = in_acc && (req_item.phase == PHASE_PAIR_A);
   assign upd_b     = in_acc && (req_item.phase == PHASE_PAIR_B);

   assign head_a = {req_item.knob1_sample, req_item.knob2_sample};
   assign head_b = {req_item.knob3_sample, req_item.cv_sample};

   // Sample chains: pair A holds knob1/knob2, pair B holds knob3/cv.
   for (genvar i = 0; i < RING_DEPTH; i++) begin : g_chain
      if (i == 0) begin : g_head
         pmba_cell #(.WIDTH(PAIR_WIDTH)) u_cell_a (
            .clock(clock), .reset(reset), .shift_en(upd_a), .d(head_a), .q(tap_a[i])
         );
         pmba_cell #(.WIDTH(PAIR_WIDTH)) u_cell_b (
            .clock(clock), .reset(reset), .shift_en(upd_b), .d(head_b), .q(tap_b[i])
         );
      end else begin : g_body
         pmba_cell #(.WIDTH(PAIR_WIDTH)) u_cell_a (
            .clock(clock), .reset(reset), .shift_en(upd_a), .d(tap_a[i-1]), .q(tap_a[i])
         );
         pmba_cell #(.WIDTH(PAIR_WIDTH)) u_cell_b (
            .clock(clock), .reset(reset), .shift_en(upd_b), .d(tap_b[i-1]), .q(tap_b[i])
         );
      end
   end

   assign old_k1 = tap_a[KNOB_LAG-1][SAMPLE_WIDTH +: SAMPLE_WIDTH];
   assign old_k2 = tap_a[KNOB_LAG-1][0 +: SAMPLE_WIDTH];
   assign old_k3 = tap_b[KNOB_LAG-1][SAMPLE_WIDTH +: SAMPLE_WIDTH];
   assign old_cv = tap_b[CV_LAG-1][0 +: SAMPLE_WIDTH];

   pmba_accum #(.WINDOW_LOG2(KNOB_WINDOW_LOG2)) u_acc_k1 (
      .clock(clock), .reset(reset), .update(upd_a),
      .sample(req_item.knob1_sample), .old_sample(old_k1),
      .average(new_item.knob1_average)
   );
   pmba_accum #(.WINDOW_LOG2(KNOB_WINDOW_LOG2)) u_acc_k2 (
      .clock(clock), .reset(reset), .update(upd_a),
      .sample(req_item.knob2_sample), .old_sample(old_k2),
      .average(new_item.knob2_average)
   );
   pmba_accum #(.WINDOW_LOG2(KNOB_WINDOW_LOG2)) u_acc_k3 (
      .clock(clock), .reset(reset), .update(upd_b),
      .sample(req_item.knob3_sample), .old_sample(old_k3),
      .average(new_item.knob3_average)
   );
   pmba_accum #(.WINDOW_LOG2(CV_WINDOW_LOG2)) u_acc_cv (
      .clock(clock), .reset(reset), .update(upd_b),
      .sample(req_item.cv_sample), .old_sample(old_cv),
      .average(new_item.cv_average)
   );

   always_comb begin
      case (req_item.phase)
         PHASE_ZERO:   next_phase = PHASE_PAIR_A;
         PHASE_PAIR_A: next_phase = PHASE_PAIR_B;
         PHASE_PAIR_B: next_phase = PHASE_WRAP;
         PHASE_WRAP:   next_phase = PHASE_PAIR_A;
         default:      next_phase = PHASE_PAIR_A;
      endcase
   end

   assign new_item.next_phase = next_phase;

   // Output register with a skid entry behind it.
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_item_in   = rsp_item_ff;
      skid_valid_in = skid_valid_ff;
      skid_item_in  = skid_item_ff;
      if (out_take || !rsp_valid_ff) begin
         if (skid_valid_ff) begin
            rsp_valid_in  = 1'b1;
            rsp_item_in   = skid_item_ff;
            skid_valid_in = 1'b0;
         end else begin
            rsp_valid_in = in_acc;
            if (in_acc) begin
               rsp_item_in = new_item;
            end
         end
      end else if (in_acc) begin
         // Hold the waiting result; park the new item.
         skid_valid_in = 1'b1;
         skid_item_in  = new_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_item_ff  <= rsp_item_in;
      skid_item_ff <= skid_item_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid entry held while output register empty");

   a_accept_shows: assert property (@(posedge clock) disable iff (reset)
      in_acc |=> rsp_valid_ff)
      else $error("accepted item produced no result");

   a_skid_only_on_stall: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_valid_ff) |-> $past(rsp_valid_ff && rsp_stall))
      else $error("skid entry filled without an output stall");

   a_next_phase_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_item_ff.next_phase != PHASE_ZERO))
      else $error("result carries next phase zero");

endmodule

`default_nettype wire

// File: sim/tb_phased_multichannel_boxcar_average_unit.sv
// Self-checking testbench for the phased multichannel boxcar averager.
`timescale 1ns / 1ps

module tb_phased_multichannel_boxcar_average_unit;
   import pmba_pkg::*;

   localparam int KNOB_SUM_WIDTH = SAMPLE_WIDTH + DEF_KNOB_WINDOW_LOG2;
   localparam int CV_SUM_WIDTH   = SAMPLE_WIDTH + DEF_CV_WINDOW_LOG2;
   localparam int SLOT_WIDTH     = $clog2(DEF_RING_DEPTH);
   localparam int RANDOM_ITEMS   = 1080;
   localparam int IDLE_LIMIT     = 4000;
   localparam int DRAIN_CYCLES   = 20;

   localparam logic [SAMPLE_WIDTH-1:0] SAMPLE_MAX = {SAMPLE_WIDTH{1'b1}};
   localparam logic [SAMPLE_WIDTH-1:0] SAMPLE_ODD = 12'hAAA;
   localparam logic [SAMPLE_WIDTH-1:0] SAMPLE_EVN = 12'h555;

   typedef enum int {STYLE_RANDOM, STYLE_STEADY, STYLE_RAIL, STYLE_TOGGLE} sample_style_type;
   typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_item_type req_item = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_item_type rsp_item;

   req_item_type pending_items[$];
   rsp_item_type expected_averages[$];
   logic         req_taken = 1'b0;
   int           fail_count = 0;
   int           idle_cycles = 0;
   int           burst_left = 1;
   int           gap_left = 0;
   int           stall_left = 0;
   stall_mode_type stall_mode = STALL_NONE;

   // Running state of the averager as the checker sees it
   logic [SAMPLE_WIDTH-1:0]   knob1_ring [DEF_RING_DEPTH];
   logic [SAMPLE_WIDTH-1:0]   knob2_ring [DEF_RING_DEPTH];
   logic [SAMPLE_WIDTH-1:0]   knob3_ring [DEF_RING_DEPTH];
   logic [SAMPLE_WIDTH-1:0]   cv_ring [DEF_RING_DEPTH];
   logic [SLOT_WIDTH-1:0]     pair_a_slot;
   logic [SLOT_WIDTH-1:0]     pair_b_slot;
   logic [KNOB_SUM_WIDTH-1:0] knob1_sum;
   logic [KNOB_SUM_WIDTH-1:0] knob2_sum;
   logic [KNOB_SUM_WIDTH-1:0] knob3_sum;
   logic [CV_SUM_WIDTH-1:0]   cv_sum;
   logic [SAMPLE_WIDTH-1:0]   held_knob1;
   logic [SAMPLE_WIDTH-1:0]   held_knob2;
   logic [SAMPLE_WIDTH-1:0]   held_knob3;
   logic [SAMPLE_WIDTH-1:0]   held_cv;

   phased_multichannel_boxcar_average_unit u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

   always #1 clock = ~clock;

   function automatic phase_type phase_after(phase_type phase);
      return (phase == PHASE_WRAP) ? PHASE_PAIR_A : phase_type'(phase + 1'b1);
   endfunction

   function automatic rsp_item_type predict_averages(req_item_type item);
      rsp_item_type          result;
      logic [SLOT_WIDTH-1:0] slot;
      logic [SLOT_WIDTH-1:0] leaving;
      case (item.phase)
         PHASE_PAIR_A: begin
            slot = pair_a_slot;
            leaving = slot - SLOT_WIDTH'(1 << DEF_KNOB_WINDOW_LOG2);
            knob1_sum = knob1_sum + item.knob1_sample - knob1_ring[leaving];
            knob2_sum = knob2_sum + item.knob2_sample - knob2_ring[leaving];
            knob1_ring[slot] = item.knob1_sample;
            knob2_ring[slot] = item.knob2_sample;
            pair_a_slot = slot + 1'b1;
            held_knob1 = SAMPLE_WIDTH'(knob1_sum >> DEF_KNOB_WINDOW_LOG2);
            held_knob2 = SAMPLE_WIDTH'(knob2_sum >> DEF_KNOB_WINDOW_LOG2);
         end
         PHASE_PAIR_B: begin
            slot = pair_b_slot;
            leaving = slot - SLOT_WIDTH'(1 << DEF_KNOB_WINDOW_LOG2);
            knob3_sum = knob3_sum + item.knob3_sample - knob3_ring[leaving];
            knob3_ring[slot] = item.knob3_sample;
            // cv reads back over its shorter window
            leaving = slot - SLOT_WIDTH'(1 << DEF_CV_WINDOW_LOG2);
            cv_sum = cv_sum + item.cv_sample - cv_ring[leaving];
            cv_ring[slot] = item.cv_sample;
            pair_b_slot = slot + 1'b1;
            held_knob3 = SAMPLE_WIDTH'(knob3_sum >> DEF_KNOB_WINDOW_LOG2);
            held_cv = SAMPLE_WIDTH'(cv_sum >> DEF_CV_WINDOW_LOG2);
         end
         default: ;
      endcase
      result.next_phase = phase_after(item.phase);
      result.knob1_average = held_knob1;
      result.knob2_average = held_knob2;
      result.knob3_average = held_knob3;
      result.cv_average = held_cv;
      return result;
   endfunction

   function automatic logic [SAMPLE_WIDTH-1:0] draw_sample(sample_style_type style,
                                                          logic [SAMPLE_WIDTH-1:0] anchor);
      case (style)
         STYLE_STEADY: return anchor ^ SAMPLE_WIDTH'($urandom_range(0, 7));
         STYLE_RAIL:   return anchor[SAMPLE_WIDTH-1] ? SAMPLE_MAX : '0;
         STYLE_TOGGLE: return ($urandom_range(0, 1) == 0) ? SAMPLE_MAX : '0;
         default:      return SAMPLE_WIDTH'($urandom_range(0, 4095));
      endcase
   endfunction

   task automatic check_field(string field_name, int unsigned expected_value,
                              int unsigned actual_value);
      if (expected_value != actual_value) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d",
                  $time, field_name, expected_value, actual_value);
         fail_count++;
      end
   endtask

   // Sender: bursts of items separated by random gaps
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (gap_left > 0) begin
            gap_left = gap_left - 1;
            req_valid <= 1'b0;
         end else if (pending_items.size() != 0) begin
            req_item <= pending_items.pop_front();
            req_valid <= 1'b1;
            burst_left = burst_left - 1;
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 40);
               gap_left = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 8);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver: stall pattern changes to a randomly drawn mode at the end of each random-length stretch
   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_mode = stall_mode_type'($urandom_range(0, 3));
         stall_left = $urandom_range(5, 60);
      end
      stall_left = stall_left - 1;
      case (stall_mode)
         STALL_LIGHT:    rsp_stall <= ($urandom_range(0, 3) == 0);
         STALL_HEAVY:    rsp_stall <= ($urandom_range(0, 4) != 0);
         STALL_PERIODIC: rsp_stall <= ((stall_left % 4) != 0);
         default:        rsp_stall <= 1'b0;
      endcase
   end

   always @(posedge clock) begin : monitor
      rsp_item_type expected_item;
      int           k;
      if (reset) begin
         for (k = 0; k < DEF_RING_DEPTH; k++) begin
            knob1_ring[k] = '0;
            knob2_ring[k] = '0;
            knob3_ring[k] = '0;
            cv_ring[k] = '0;
         end
         pair_a_slot = '0;
         pair_b_slot = '0;
         knob1_sum = '0;
         knob2_sum = '0;
         knob3_sum = '0;
         cv_sum = '0;
         held_knob1 = '0;
         held_knob2 = '0;
         held_knob3 = '0;
         held_cv = '0;
         idle_cycles = 0;
         req_taken <= 1'b0;
      end else begin
         // check the outgoing item first: it never belongs to this cycle's input
         if (rsp_valid && !rsp_stall) begin
            if (expected_averages.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual %h", $time, rsp_item);
               fail_count++;
            end else begin
               expected_item = expected_averages.pop_front();
               check_field("next_phase", expected_item.next_phase, rsp_item.next_phase);
               check_field("knob1_average", expected_item.knob1_average,
                           rsp_item.knob1_average);
               check_field("knob2_average", expected_item.knob2_average,
                           rsp_item.knob2_average);
               check_field("knob3_average", expected_item.knob3_average,
                           rsp_item.knob3_average);
               check_field("cv_average", expected_item.cv_average, rsp_item.cv_average);
            end
         end
         if (req_valid && !req_stall)
            expected_averages.push_back(predict_averages(req_item));
         req_taken <= req_valid && !req_stall;
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles = 0;
         else
            idle_cycles = idle_cycles + 1;
         if (idle_cycles == IDLE_LIMIT) begin
            $display("FAILURE");
            $finish;
         end
      end
   end

   initial begin
      sample_style_type        style;
      phase_type               phase;
      logic [SAMPLE_WIDTH-1:0] anchor [4];
      int                      segment_left;
      int                      item_count;
      int                      i;

      // Ramp from reset, idle phases, rails and alternating bit patterns
      pending_items.push_back(req_item_type'{PHASE_ZERO, 12'd0, 12'd0, 12'd0, 12'd0});
      pending_items.push_back(req_item_type'{PHASE_WRAP, SAMPLE_MAX, SAMPLE_MAX,
                                             SAMPLE_MAX, SAMPLE_MAX});
      for (i = 0; i < 6; i++) begin
         pending_items.push_back(req_item_type'{PHASE_PAIR_A, SAMPLE_MAX, SAMPLE_MAX,
                                                SAMPLE_MAX, SAMPLE_MAX});
         pending_items.push_back(req_item_type'{PHASE_PAIR_B, SAMPLE_MAX, SAMPLE_MAX,
                                                SAMPLE_MAX, SAMPLE_MAX});
      end
      pending_items.push_back(req_item_type'{PHASE_ZERO, SAMPLE_MAX, SAMPLE_MAX,
                                             SAMPLE_MAX, SAMPLE_MAX});
      pending_items.push_back(req_item_type'{PHASE_WRAP, SAMPLE_MAX, SAMPLE_MAX,
                                             SAMPLE_MAX, SAMPLE_MAX});
      pending_items.push_back(req_item_type'{PHASE_PAIR_A, 12'd0, 12'd0, 12'd0, 12'd0});
      pending_items.push_back(req_item_type'{PHASE_PAIR_B, 12'd0, 12'd0, 12'd0, 12'd0});
      pending_items.push_back(req_item_type'{PHASE_PAIR_A, SAMPLE_ODD, SAMPLE_EVN,
                                             SAMPLE_ODD, SAMPLE_EVN});
      pending_items.push_back(req_item_type'{PHASE_PAIR_B, SAMPLE_EVN, SAMPLE_ODD,
                                             SAMPLE_EVN, SAMPLE_ODD});
      pending_items.push_back(req_item_type'{PHASE_ZERO, SAMPLE_ODD, SAMPLE_ODD,
                                             SAMPLE_ODD, SAMPLE_ODD});
      pending_items.push_back(req_item_type'{PHASE_WRAP, SAMPLE_EVN, SAMPLE_EVN,
                                             SAMPLE_EVN, SAMPLE_EVN});

      // Mostly well-ordered phase cycles with occasional out-of-order phases
      item_count = 0;
      segment_left = 0;
      phase = PHASE_PAIR_A;
      while (item_count < RANDOM_ITEMS) begin
         if (segment_left == 0) begin
            segment_left = $urandom_range(8, 120);
            style = sample_style_type'($urandom_range(0, 3));
            for (i = 0; i < 4; i++)
               anchor[i] = SAMPLE_WIDTH'($urandom_range(0, 4095));
            phase = phase_type'($urandom_range(0, 3));
         end
         segment_left = segment_left - 1;
         if ($urandom_range(0, 9) == 0)
            phase = phase_type'($urandom_range(0, 3));
         pending_items.push_back(req_item_type'{phase, draw_sample(style, anchor[0]),
                                                draw_sample(style, anchor[1]),
                                                draw_sample(style, anchor[2]),
                                                draw_sample(style, anchor[3])});
         item_count++;
         phase = phase_after(phase);
      end

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_items.size() != 0 || req_valid)
         @(posedge clock);
      while (expected_averages.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

// File: phased_multichannel_boxcar_average_unit.f
src/pmba_pkg.sv
src/pmba_cell.sv
src/pmba_accum.sv
src/phased_multichannel_boxcar_average_unit.sv
sim/tb_phased_multichannel_boxcar_average_unit.sv
